FILE: src/lnw_pkg.sv
package lnw_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEVICE_ADDRESS = 2'd0,
    REG_GAP_TICKS      = 2'd1,
    REG_BACKLIGHT_ON   = 2'd2
  } cfg_reg_t;

  localparam logic [6:0]  DeviceAddressReset = 7'h27;
  localparam logic [15:0] GapTicksReset = 16'd500;
  localparam logic        BacklightReset = 1'b1;

  localparam logic [2:0] Writes = 3'd6;

  localparam logic [7:0] HighNibbleMask = 8'hf0;
  localparam logic [7:0] BacklightBit = 8'h08;
  localparam logic [7:0] EnableBit = 8'h04;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_GAP   = 5'd1,
    PH_S1    = 5'd2,
    PH_S2    = 5'd3,
    PH_BSET  = 5'd4,
    PH_BHIGH = 5'd5,
    PH_BLOW  = 5'd6,
    PH_AREL  = 5'd7,
    PH_AHIGH = 5'd8,
    PH_ALOW  = 5'd9,
    PH_P1    = 5'd10,
    PH_P2    = 5'd11,
    PH_P3    = 5'd12
  } bus_phase_t;

endpackage

FILE: src/lcd_nibble_i2c_writer.sv
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------
// input    | in_valid / in_ready   | cmd, data_byte, is_char, sda_in
// result   | out_valid / out_ready | scl_release, sda_release, busy_res,
//          |                       | byte_done, ack_missing, load_refused
// config   | cfg_we (no wait)      | cfg_index, cfg_data
//
// each accepted item updates the sequencer state and loads the result register at
// the same clock edge, so items enter every cycle while in_ready is high.
// the single result register holds each result; in_ready stays high
// while that register is empty or being taken, so a stalled result stalls input.
// rst is synchronous and returns the config registers to their defaults and the
// bus lines to released.
module lcd_nibble_i2c_writer
  import lnw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic [7:0]          data_byte,
  input  logic                is_char,
  input  logic                sda_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                scl_release,
  output logic                sda_release,
  output logic                busy_res,
  output logic                byte_done,
  output logic                ack_missing,
  output logic                load_refused,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [6:0]  device_address;
  logic [15:0] gap_ticks;
  logic        backlight_on;

  bus_phase_t  bus_phase, bus_phase_next;
  logic [7:0]  latched_byte, latched_byte_next;
  logic        latched_select, latched_select_next;
  logic [2:0]  write_index, write_index_next;
  logic [3:0]  bit_counter, bit_counter_next;
  logic [7:0]  shift_register, shift_register_next;
  logic [15:0] gap_counter, gap_counter_next;
  logic [1:0]  line_levels, line_levels_next;
  logic        ack_flag, ack_flag_next;
  logic        done_next, refused_next;

  logic        in_accept;
  logic        busy;
  logic        tick;
  logic        gap_live;
  logic [15:0] gap_inc;
  logic [2:0]  write_inc;
  logic        finish_now;
  logic [3:0]  bit_inc;
  logic [7:0]  exp_byte;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign busy      = (bus_phase != PH_IDLE);
  assign tick      = in_accept && !cmd && busy;
  assign gap_live  = (gap_counter < gap_ticks);
  assign gap_inc   = gap_counter + 16'd1;
  assign write_inc = write_index + 3'd1;
  assign bit_inc   = bit_counter + 4'd1;

  // expander byte: nibble, select, backlight, enable on the strobe writes
  always_comb begin
    if (write_index < 3'd3) begin
      exp_byte = latched_byte & HighNibbleMask;
    end else begin
      exp_byte = {latched_byte[3:0], 4'h0};
    end
    exp_byte[0] = latched_select;
    if (backlight_on) begin
      exp_byte = exp_byte | BacklightBit;
    end
    if (write_index == 3'd1 || write_index == 3'd4) begin
      exp_byte = exp_byte | EnableBit;
    end
  end

  // end of the whole byte: last gap expired, or stop with a zero final gap
  always_comb begin
    finish_now = 1'b0;
    if (tick) begin
      case (bus_phase)
        PH_GAP: begin
          finish_now = (write_index >= Writes) && (!gap_live || gap_inc >= gap_ticks);
        end
        PH_P3: begin
          finish_now = (write_inc >= Writes) && (gap_ticks == 16'd0);
        end
        default: finish_now = 1'b0;
      endcase
    end
  end

  // next phase
  always_comb begin
    bus_phase_next = bus_phase;
    if (in_accept && cmd && !busy) begin
      bus_phase_next = PH_GAP;
    end else if (finish_now) begin
      bus_phase_next = PH_IDLE;
    end else if (tick) begin
      case (bus_phase)
        PH_GAP:   bus_phase_next = gap_live ? PH_GAP : PH_S2;
        PH_S1:    bus_phase_next = PH_S2;
        PH_S2:    bus_phase_next = PH_BSET;
        PH_BSET:  bus_phase_next = PH_BHIGH;
        PH_BHIGH: bus_phase_next = PH_BLOW;
        PH_BLOW:  bus_phase_next = (bit_inc[2:0] == 3'd0) ? PH_AREL : PH_BSET;
        PH_AREL:  bus_phase_next = PH_AHIGH;
        PH_AHIGH: bus_phase_next = PH_ALOW;
        PH_ALOW:  bus_phase_next = (bit_counter == 4'd8) ? PH_BSET : PH_P1;
        PH_P1:    bus_phase_next = PH_P2;
        PH_P2:    bus_phase_next = PH_P3;
        PH_P3:    bus_phase_next = PH_GAP;
        default:  bus_phase_next = PH_IDLE;
      endcase
    end
  end

  // datapath and result fields
  always_comb begin
    latched_byte_next   = latched_byte;
    latched_select_next = latched_select;
    write_index_next    = write_index;
    bit_counter_next    = bit_counter;
    shift_register_next = shift_register;
    gap_counter_next    = gap_counter;
    line_levels_next    = line_levels;
    ack_flag_next       = ack_flag;
    done_next           = 1'b0;
    refused_next        = 1'b0;
    if (in_accept) begin
      if (cmd) begin
        if (busy) begin
          refused_next = 1'b1;
        end else begin
          latched_byte_next   = data_byte;
          latched_select_next = is_char;
          write_index_next    = 3'd0;
          bit_counter_next    = 4'd0;
          gap_counter_next    = 16'd0;
          ack_flag_next       = 1'b0;
          line_levels_next    = 2'b11;
        end
      end else if (busy) begin
        case (bus_phase)
          PH_GAP: begin
            if (gap_live) begin
              gap_counter_next = gap_inc;
            end else if (write_index < Writes) begin
              // zero remaining gap: start condition on this tick
              line_levels_next = 2'b10;
            end
          end
          PH_S1: line_levels_next = 2'b10;
          PH_S2: begin
            line_levels_next[1] = 1'b0;
            bit_counter_next    = 4'd0;
            shift_register_next = {device_address, 1'b0};
          end
          PH_BSET: begin
            line_levels_next[0] = shift_register[7];
            shift_register_next = {shift_register[6:0], 1'b0};
          end
          PH_BHIGH: line_levels_next[1] = 1'b1;
          PH_BLOW: begin
            line_levels_next[1] = 1'b0;
            bit_counter_next    = bit_inc;
          end
          PH_AREL: line_levels_next[0] = 1'b1;
          PH_AHIGH: begin
            line_levels_next[1] = 1'b1;
            if (sda_in) begin
              ack_flag_next = 1'b1;
            end
          end
          PH_ALOW: begin
            line_levels_next[1] = 1'b0;
            if (bit_counter == 4'd8) begin
              shift_register_next = exp_byte;
            end
          end
          PH_P1: line_levels_next[0] = 1'b0;
          PH_P2: line_levels_next[1] = 1'b1;
          PH_P3: begin
            line_levels_next[0] = 1'b1;
            write_index_next    = write_inc;
            gap_counter_next    = 16'd0;
          end
          default: line_levels_next = 2'b11;
        endcase
        if (finish_now) begin
          write_index_next = 3'd0;
          gap_counter_next = 16'd0;
          line_levels_next = 2'b11;
          done_next        = 1'b1;
        end
      end else begin
        line_levels_next = 2'b11;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DeviceAddressReset;
      gap_ticks      <= GapTicksReset;
      backlight_on   <= BacklightReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        REG_GAP_TICKS:      gap_ticks      <= cfg_data;
        REG_BACKLIGHT_ON:   backlight_on   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_phase      <= PH_IDLE;
      latched_byte   <= 8'd0;
      latched_select <= 1'b0;
      write_index    <= 3'd0;
      bit_counter    <= 4'd0;
      shift_register <= 8'd0;
      gap_counter    <= 16'd0;
      line_levels    <= 2'b11;
      ack_flag       <= 1'b0;
    end else begin
      bus_phase      <= bus_phase_next;
      latched_byte   <= latched_byte_next;
      latched_select <= latched_select_next;
      write_index    <= write_index_next;
      bit_counter    <= bit_counter_next;
      shift_register <= shift_register_next;
      gap_counter    <= gap_counter_next;
      line_levels    <= line_levels_next;
      ack_flag       <= ack_flag_next;
    end
  end

  // result register: one result per input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      scl_release  <= line_levels_next[1];
      sda_release  <= line_levels_next[0];
      busy_res     <= (bus_phase_next != PH_IDLE);
      byte_done    <= done_next;
      ack_missing  <= ack_flag_next;
      load_refused <= refused_next;
    end
  end

endmodule
